[rtl/svdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdf_pkg: shared types and tables for the six-valued gate evaluator
// Value codes, gate kinds, table-set codes and the AND/OR/NOT tables.
// ----------------------------------------------------------------------------
package svdf_pkg;

   localparam int NODE_COUNT_DEF = 1024;

   localparam int KIND_W  = 4;
   localparam int NODE_W  = 10;
   localparam int VALUE_W = 3;
   localparam int MODE_W  = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index of the table-set register
   localparam logic [CSR_ADDR_W-3:0] CSR_SIM_MODE = '0;

   typedef enum logic [VALUE_W-1:0] {
      V_S0 = 3'd0,
      V_R1 = 3'd1,
      V_F0 = 3'd2,
      V_S1 = 3'd3,
      V_X1 = 3'd4,
      V_X0 = 3'd5
   } value_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INPUT = 4'd0,
      KIND_AND   = 4'd1,
      KIND_NAND  = 4'd2,
      KIND_OR    = 4'd3,
      KIND_NOR   = 4'd4,
      KIND_XOR   = 4'd5,
      KIND_XNOR  = 4'd6,
      KIND_BUFF  = 4'd7,
      KIND_NOT   = 4'd8,
      KIND_FROM  = 4'd9,
      KIND_OTHER = 4'd10
   } kind_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_ROBUST     = 2'd0,
      MODE_NONROBUST  = 2'd1,
      MODE_FUNCTIONAL = 2'd2
   } mode_type;

   localparam value_type OR_TAB [3][6][6] = '{
      '{'{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_R1, V_X1, V_X1, V_S1, V_X1, V_X1},
        '{V_F0, V_X1, V_F0, V_S1, V_X1, V_F0},
        '{V_S1, V_S1, V_S1, V_S1, V_S1, V_S1},
        '{V_X1, V_X1, V_X1, V_S1, V_X1, V_X1},
        '{V_X0, V_X1, V_F0, V_S1, V_X1, V_X0}},
      '{'{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_R1, V_X1, V_R1, V_S1, V_X1, V_R1},
        '{V_F0, V_R1, V_F0, V_S1, V_X1, V_F0},
        '{V_S1, V_S1, V_S1, V_S1, V_S1, V_S1},
        '{V_X1, V_X1, V_X1, V_S1, V_X1, V_X1},
        '{V_X0, V_R1, V_F0, V_S1, V_X1, V_X0}},
      '{'{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_R1, V_R1, V_X1, V_S1, V_X1, V_X1},
        '{V_F0, V_X1, V_F0, V_S1, V_X1, V_F0},
        '{V_S1, V_S1, V_S1, V_S1, V_S1, V_S1},
        '{V_X1, V_X1, V_X1, V_S1, V_X1, V_X1},
        '{V_X0, V_X1, V_F0, V_S1, V_X1, V_X0}}
   };

   localparam value_type AND_TAB [3][6][6] = '{
      '{'{V_S0, V_S0, V_S0, V_S0, V_S0, V_S0},
        '{V_S0, V_R1, V_X0, V_R1, V_R1, V_X0},
        '{V_S0, V_X0, V_X0, V_F0, V_X0, V_X0},
        '{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_S0, V_R1, V_X0, V_X1, V_X1, V_X0},
        '{V_S0, V_X0, V_X0, V_X0, V_X0, V_X0}},
      '{'{V_S0, V_S0, V_S0, V_S0, V_S0, V_S0},
        '{V_S0, V_R1, V_F0, V_R1, V_R1, V_X0},
        '{V_S0, V_F0, V_X0, V_F0, V_F0, V_X0},
        '{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_S0, V_R1, V_F0, V_X1, V_X1, V_X0},
        '{V_S0, V_X0, V_X0, V_X0, V_X0, V_X0}},
      '{'{V_S0, V_S0, V_S0, V_S0, V_S0, V_S0},
        '{V_S0, V_R1, V_X0, V_R1, V_R1, V_X0},
        '{V_S0, V_X0, V_F0, V_F0, V_X0, V_X0},
        '{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_S0, V_R1, V_X0, V_X1, V_X1, V_X0},
        '{V_S0, V_X0, V_X0, V_X0, V_X0, V_X0}}
   };

   localparam value_type NOT_TAB [6] = '{V_S1, V_F0, V_R1, V_S0, V_X0, V_X1};

   function automatic value_type or_tab(input mode_type m, input value_type a,
                                        input value_type b);
      return OR_TAB[m][a][b];
   endfunction

   function automatic value_type and_tab(input mode_type m, input value_type a,
                                         input value_type b);
      return AND_TAB[m][a][b];
   endfunction

   function automatic value_type not_val(input value_type a);
      return NOT_TAB[a];
   endfunction

endpackage

[rtl/svdf_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdf_req_if: request channel of the gate evaluator
// One fan-in edge per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface svdf_req_if import svdf_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   req_type;
   logic [NODE_W-1:0]   dest_node;
   logic [NODE_W-1:0]   fanin_node;
   logic [VALUE_W-1:0]  pattern_value;
   logic                first_fanin;
   logic                last_fanin;

   modport source (output valid, req_type, dest_node, fanin_node, pattern_value,
                   first_fanin, last_fanin, input ready);
   modport sink   (input valid, req_type, dest_node, fanin_node, pattern_value,
                   first_fanin, last_fanin, output ready);
endinterface

[rtl/svdf_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdf_rsp_if: result channel of the gate evaluator
// Gate index, six-valued value and transition mark, valid/ready handshake.
// ----------------------------------------------------------------------------
interface svdf_rsp_if import svdf_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [NODE_W-1:0]   node_index;
   logic [VALUE_W-1:0]  node_value;
   logic                transition_mark;

   modport source (output valid, node_index, node_value, transition_mark,
                   input ready);
   modport sink   (input valid, node_index, node_value, transition_mark,
                   output ready);
endinterface

[rtl/six_valued_delay_fault_gate_sim.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_valued_delay_fault_gate_sim: six-valued two-frame gate evaluator
// Folds fan-in edges through the selected AND/OR tables, stores gate values
// in a node-value memory and emits each finished gate value.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless a waiting result holds a last edge
//   in E; the single write port of the node-value memory and the registered
//   read ports set the pipeline.
// Pipeline: memory read at the accept edge into stage E, then evaluate and
//   write-back into the output register, which drives the result on rsp_ch.
// Reset: synchronous; afterwards a clearing pass writes S0 into every node
//   entry, during which no request is accepted.
// ----------------------------------------------------------------------------
module six_valued_delay_fault_gate_sim import svdf_pkg::*; #(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   svdf_req_if.sink              req_ch,
   svdf_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // memory address width, and a compare width that holds NODE_COUNT itself
   localparam int ADDR_W = $clog2(NODE_COUNT);
   localparam int CMP_W  = (ADDR_W + 1 > NODE_W) ? ADDR_W + 1 : NODE_W;
   localparam logic [CMP_W-1:0]  NODE_LIMIT = CMP_W'(NODE_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NODE_COUNT - 1);

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [MODE_W-1:0] mode_ff;
   logic              csr_hit;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_SIM_MODE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ROBUST;
      end else if (csr_wr && csr_hit) begin
         mode_ff <= csr_pwdata[MODE_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(mode_ff) : '0;

   // mode code 3 behaves as the functional table set
   mode_type mode_eff;
   assign mode_eff = (mode_ff > MODE_FUNCTIONAL) ? MODE_FUNCTIONAL
                                                 : mode_type'(mode_ff);

   // ---------------------------------------------------------------------
   // Clearing pass after reset
   // ---------------------------------------------------------------------
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Handshake and pipeline control
   //   stage E holds the request whose memory data has just come back
   // ---------------------------------------------------------------------
   logic e_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic e_fire;
   logic req_fire;
   logic e_last_ff;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign e_fire       = e_valid_ff && (!e_last_ff || out_free);
   assign req_ch.ready = !clr_busy_ff && (!e_valid_ff || e_fire);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // request decode at accept
   logic [CMP_W-1:0]  fan_ext;
   logic [CMP_W-1:0]  dst_ext;
   logic [ADDR_W-1:0] fan_addr;
   logic [ADDR_W-1:0] dst_addr;
   logic              fan_ok;
   logic              dst_ok;

   assign fan_ext  = CMP_W'(req_ch.fanin_node);
   assign dst_ext  = CMP_W'(req_ch.dest_node);
   assign fan_addr = ADDR_W'(fan_ext);
   assign dst_addr = ADDR_W'(dst_ext);
   assign fan_ok   = fan_ext < NODE_LIMIT;
   assign dst_ok   = dst_ext < NODE_LIMIT;

   // E stage registers
   logic [KIND_W-1:0]  e_kind_ff;
   logic [NODE_W-1:0]  e_dest_ff;
   logic [ADDR_W-1:0]  e_addr_ff;
   logic [VALUE_W-1:0] e_pat_ff;
   logic               e_first_ff;
   logic               e_fan_ok_ff;
   logic               e_dst_ok_ff;
   logic               e_fan_fwd_ff;
   logic               e_dst_fwd_ff;
   value_type          e_fwd_val_ff;
   value_type          fan_rd_ff;
   value_type          dst_rd_ff;

   // E stage results
   value_type res;
   value_type main_in;
   value_type inv_in;
   logic      e_wr;

   // a write from E at the same edge as an accept is forwarded to the
   // accepted request, since its memory read sees the old entry
   logic fan_fwd;
   logic dst_fwd;
   assign fan_fwd = e_fire && e_wr && (req_ch.fanin_node == e_dest_ff);
   assign dst_fwd = e_fire && e_wr && (req_ch.dest_node == e_dest_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (req_fire) begin
         e_valid_ff <= 1'b1;
      end else if (e_fire) begin
         e_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         e_kind_ff    <= req_ch.req_type;
         e_dest_ff    <= req_ch.dest_node;
         e_addr_ff    <= dst_addr;
         e_pat_ff     <= req_ch.pattern_value;
         e_first_ff   <= req_ch.first_fanin;
         e_last_ff    <= req_ch.last_fanin;
         e_fan_ok_ff  <= fan_ok;
         e_dst_ok_ff  <= dst_ok;
         e_fan_fwd_ff <= fan_fwd;
         e_dst_fwd_ff <= dst_fwd;
         e_fwd_val_ff <= res;
      end
   end

   // ---------------------------------------------------------------------
   // Node-value memory: one write port, two registered read ports
   // ---------------------------------------------------------------------
   value_type node_mem [NODE_COUNT];

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         node_mem[clr_addr_ff] <= V_S0;
      end else if (e_fire && e_wr) begin
         node_mem[e_addr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         fan_rd_ff <= node_mem[fan_addr];
         dst_rd_ff <= node_mem[dst_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Evaluate: fold the edge into the accumulators, finish on last edge
   // ---------------------------------------------------------------------
   value_type main_ff;
   value_type inv_ff;
   value_type fan_val;
   value_type fan_inv;
   value_type dst_val;
   value_type pat_val;
   mode_type  xor_mode;
   kind_type  kind;

   assign kind     = kind_type'(e_kind_ff);
   assign fan_val  = !e_fan_ok_ff ? V_S0 : (e_fan_fwd_ff ? e_fwd_val_ff : fan_rd_ff);
   assign dst_val  = !e_dst_ok_ff ? V_S0 : (e_dst_fwd_ff ? e_fwd_val_ff : dst_rd_ff);
   assign fan_inv  = not_val(fan_val);
   assign pat_val  = (e_pat_ff > V_X0) ? V_X0 : value_type'(e_pat_ff);
   // non-robust XOR finishes with the robust AND table
   assign xor_mode = (mode_eff == MODE_NONROBUST) ? MODE_ROBUST : mode_eff;

   always_comb begin
      main_in = main_ff;
      inv_in  = inv_ff;
      case (kind) inside
         KIND_AND, KIND_NAND: begin
            main_in = e_first_ff ? fan_val : and_tab(mode_eff, main_ff, fan_val);
         end
         KIND_OR, KIND_NOR: begin
            main_in = e_first_ff ? fan_val : or_tab(mode_eff, main_ff, fan_val);
         end
         KIND_XOR: begin
            main_in = e_first_ff ? fan_val : or_tab(mode_eff, main_ff, fan_val);
            inv_in  = e_first_ff ? fan_inv : or_tab(mode_eff, inv_ff, fan_inv);
         end
         KIND_XNOR: begin
            main_in = e_first_ff ? fan_val : and_tab(mode_eff, main_ff, fan_val);
            inv_in  = e_first_ff ? fan_inv : and_tab(mode_eff, inv_ff, fan_inv);
         end
         KIND_BUFF, KIND_NOT, KIND_FROM: begin
            if (e_first_ff) begin
               main_in = fan_val;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      e_wr = e_last_ff && e_dst_ok_ff;
      case (kind) inside
         KIND_INPUT:                              res = pat_val;
         KIND_AND, KIND_OR, KIND_BUFF, KIND_FROM: res = main_in;
         KIND_NAND, KIND_NOR, KIND_NOT:           res = not_val(main_in);
         KIND_XOR:  res = and_tab(xor_mode, main_in, inv_in);
         KIND_XNOR: res = or_tab(mode_eff, main_in, inv_in);
         default: begin
            // unknown kind: re-emit the stored value, memory untouched
            res  = dst_val;
            e_wr = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff <= V_S0;
         inv_ff  <= V_S0;
      end else if (e_fire) begin
         main_ff <= main_in;
         inv_ff  <= inv_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic [NODE_W-1:0] rsp_index_ff;
   value_type         rsp_value_ff;
   logic              rsp_mark_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (e_fire && e_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (e_fire && e_last_ff) begin
         rsp_index_ff <= e_dest_ff;
         rsp_value_ff <= res;
         rsp_mark_ff  <= (res == V_R1) || (res == V_F0);
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.node_index      = rsp_index_ff;
   assign rsp_ch.node_value      = rsp_value_ff;
   assign rsp_ch.transition_mark = rsp_mark_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_no_work_during_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !e_valid_ff && !rsp_valid_ff)
      else $error("pipeline active during clearing pass");

   a_accept_fills_e: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> e_valid_ff)
      else $error("accepted request did not reach evaluate stage");

   a_last_makes_result: assert property (@(posedge clock) disable iff (reset)
      e_fire && e_last_ff |=> rsp_valid_ff)
      else $error("finished gate produced no result");

   a_mark_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_mark_ff == ((rsp_value_ff == V_R1) || (rsp_value_ff == V_F0)))
      else $error("transition mark disagrees with value");

   a_value_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_value_ff <= V_X0)
      else $error("result value outside six-valued codes");

endmodule

[bench/svdf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdf_checker: gate value predictor and result scoreboard
// Watches the request, result and register ports of the six-valued gate
// evaluator, folds every accepted request into its own copy of the node
// values and accumulators, and compares each result with the oldest
// predicted gate value.
// ----------------------------------------------------------------------------
module svdf_checker import svdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   svdf_req_if                   req_mon,
   svdf_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int unsigned           fail_count,
   output int unsigned           results_pending,
   output int unsigned           results_checked
);

   typedef struct packed {
      logic [NODE_W-1:0] node;
      value_type         value;
      logic              mark;
   } gate_value_type;

   // OR fold per table set: [set][accumulated][incoming]
   localparam value_type FOLD_OR [3][6][6] = '{
      '{'{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_R1, V_X1, V_X1, V_S1, V_X1, V_X1},
        '{V_F0, V_X1, V_F0, V_S1, V_X1, V_F0},
        '{V_S1, V_S1, V_S1, V_S1, V_S1, V_S1},
        '{V_X1, V_X1, V_X1, V_S1, V_X1, V_X1},
        '{V_X0, V_X1, V_F0, V_S1, V_X1, V_X0}},
      '{'{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_R1, V_X1, V_R1, V_S1, V_X1, V_R1},
        '{V_F0, V_R1, V_F0, V_S1, V_X1, V_F0},
        '{V_S1, V_S1, V_S1, V_S1, V_S1, V_S1},
        '{V_X1, V_X1, V_X1, V_S1, V_X1, V_X1},
        '{V_X0, V_R1, V_F0, V_S1, V_X1, V_X0}},
      '{'{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_R1, V_R1, V_X1, V_S1, V_X1, V_X1},
        '{V_F0, V_X1, V_F0, V_S1, V_X1, V_F0},
        '{V_S1, V_S1, V_S1, V_S1, V_S1, V_S1},
        '{V_X1, V_X1, V_X1, V_S1, V_X1, V_X1},
        '{V_X0, V_X1, V_F0, V_S1, V_X1, V_X0}}
   };

   localparam value_type FOLD_AND [3][6][6] = '{
      '{'{V_S0, V_S0, V_S0, V_S0, V_S0, V_S0},
        '{V_S0, V_R1, V_X0, V_R1, V_R1, V_X0},
        '{V_S0, V_X0, V_X0, V_F0, V_X0, V_X0},
        '{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_S0, V_R1, V_X0, V_X1, V_X1, V_X0},
        '{V_S0, V_X0, V_X0, V_X0, V_X0, V_X0}},
      '{'{V_S0, V_S0, V_S0, V_S0, V_S0, V_S0},
        '{V_S0, V_R1, V_F0, V_R1, V_R1, V_X0},
        '{V_S0, V_F0, V_X0, V_F0, V_F0, V_X0},
        '{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_S0, V_R1, V_F0, V_X1, V_X1, V_X0},
        '{V_S0, V_X0, V_X0, V_X0, V_X0, V_X0}},
      '{'{V_S0, V_S0, V_S0, V_S0, V_S0, V_S0},
        '{V_S0, V_R1, V_X0, V_R1, V_R1, V_X0},
        '{V_S0, V_X0, V_F0, V_F0, V_X0, V_X0},
        '{V_S0, V_R1, V_F0, V_S1, V_X1, V_X0},
        '{V_S0, V_R1, V_X0, V_X1, V_X1, V_X0},
        '{V_S0, V_X0, V_X0, V_X0, V_X0, V_X0}}
   };

   localparam value_type INVERT [6] = '{V_S1, V_F0, V_R1, V_S0, V_X0, V_X1};

   value_type         node_values [NODE_COUNT_DEF];
   value_type         acc_main;
   value_type         acc_inv;
   logic [MODE_W-1:0] table_sel;
   gate_value_type    expected_values [$];

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] checker: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : monitor
      gate_value_type    want;
      value_type         v;
      value_type         nv;
      value_type         a;
      value_type         b;
      value_type         res;
      value_type         pat;
      mode_type          m;
      logic [KIND_W-1:0] kind;
      logic              first;
      if (reset) begin
         foreach (node_values[i])
            node_values[i] = V_S0;
         acc_main = V_S0;
         acc_inv = V_S0;
         table_sel = MODE_ROBUST;
         expected_values.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_values.size() == 0) begin
               note_failure($sformatf("unexpected result node %0d value %0d mark %0d",
                  rsp_mon.node_index, rsp_mon.node_value, rsp_mon.transition_mark));
            end else begin
               want = expected_values.pop_front();
               results_checked++;
               if (rsp_mon.node_index !== want.node || rsp_mon.node_value !== want.value ||
                   rsp_mon.transition_mark !== want.mark)
                  note_failure($sformatf(
                     "got node %0d value %0d mark %0d, expected node %0d value %0d mark %0d",
                     rsp_mon.node_index, rsp_mon.node_value, rsp_mon.transition_mark,
                     want.node, want.value, want.mark));
            end
         end

         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_SIM_MODE)
            table_sel = csr_pwdata[MODE_W-1:0];

         if (req_mon.valid && req_mon.ready) begin
            kind  = req_mon.req_type;
            first = req_mon.first_fanin;
            m     = (table_sel > MODE_FUNCTIONAL) ? MODE_FUNCTIONAL : mode_type'(table_sel);
            pat   = (req_mon.pattern_value > V_X0) ? V_X0 : value_type'(req_mon.pattern_value);
            v     = node_values[req_mon.fanin_node];
            nv    = INVERT[v];
            a     = acc_main;
            b     = acc_inv;
            case (kind)
               KIND_AND, KIND_NAND: a = first ? v : FOLD_AND[m][a][v];
               KIND_OR, KIND_NOR:   a = first ? v : FOLD_OR[m][a][v];
               KIND_XOR: begin
                  if (first) begin
                     a = v;
                     b = nv;
                  end else begin
                     b = FOLD_OR[m][b][nv];
                     a = FOLD_OR[m][a][v];
                  end
               end
               KIND_XNOR: begin
                  if (first) begin
                     a = v;
                     b = nv;
                  end else begin
                     b = FOLD_AND[m][b][nv];
                     a = FOLD_AND[m][a][v];
                  end
               end
               KIND_BUFF, KIND_NOT, KIND_FROM: begin
                  if (first)
                     a = v;
               end
               default: ;
            endcase
            acc_main = a;
            acc_inv = b;

            if (req_mon.last_fanin) begin
               case (kind)
                  KIND_INPUT:                           res = pat;
                  KIND_AND, KIND_OR, KIND_BUFF, KIND_FROM: res = a;
                  KIND_NAND, KIND_NOR, KIND_NOT:        res = INVERT[a];
                  // non-robust XOR finishes through the robust AND set
                  KIND_XOR: res = FOLD_AND[(m == MODE_NONROBUST) ? MODE_ROBUST : m][a][b];
                  KIND_XNOR:                            res = FOLD_OR[m][a][b];
                  default:                              res = node_values[req_mon.dest_node];
               endcase
               if (kind <= KIND_FROM)
                  node_values[req_mon.dest_node] = res;
               want.node  = req_mon.dest_node;
               want.value = res;
               want.mark  = (res == V_R1 || res == V_F0);
               expected_values.push_back(want);
            end
         end
         results_pending = expected_values.size();
      end
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the six-valued gate evaluator
// Streams gate netlists edge by edge through every table set, with random
// idling on both channels and two long result stalls over the phases;
// the checker beside the block predicts and compares every gate value.
// ----------------------------------------------------------------------------
module testbench;
   import svdf_pkg::*;

   // gate codes 11..15 have no name; they behave like the unknown kind
   localparam logic [KIND_W-1:0] KIND_TOP        = 4'hF;
   // table-set code 3 falls back to the functional tables
   localparam logic [MODE_W-1:0] MODE_FUNC_ALIAS = 2'd3;
   localparam int unsigned       POOL_SPAN       = 48;
   localparam int unsigned       PHASE_ITEMS     = 180;
   localparam int unsigned       STALL_CYCLES    = 300;
   // items without a result may still be in flight in the pipeline
   localparam int unsigned       DRAIN_CYCLES    = 6;
   localparam int unsigned       TIMEOUT_NS      = 800_000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned fail_count;
   int unsigned results_pending;
   int unsigned results_checked;

   // idle percentages, read by the sender and the ready driver, and the stall request
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned stall_token;
   int unsigned stall_seen;
   int unsigned hold_left;

   int unsigned       sent_count;
   logic [NODE_W-1:0] last_dest;

   svdf_req_if req_ch ();
   svdf_rsp_if rsp_ch ();

   six_valued_delay_fault_gate_sim dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   svdf_checker gate_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop: a hang anywhere ends the run as a failure.
   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

   // Result side ready. A new stall token starts a long hold-off while the
   // sender keeps offering, so the pipeline fills and backs up the input.
   always @(negedge clock) begin
      if (stall_token != stall_seen) begin
         stall_seen = stall_token;
         hold_left  = STALL_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // One fan-in edge. Called and returning at a falling edge; valid stays
   // high across back-to-back requests, dropping only for a random gap.
   task automatic send_edge(input logic [KIND_W-1:0] kind, input logic [NODE_W-1:0] dest,
                            input logic [NODE_W-1:0] src, input logic [VALUE_W-1:0] pat,
                            input logic first, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= kind;
      req_ch.dest_node     <= dest;
      req_ch.fanin_node    <= src;
      req_ch.pattern_value <= pat;
      req_ch.first_fanin   <= first;
      req_ch.last_fanin    <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // Table-set write, only once the block has drained. Upper data bits are
   // random: only the low two bits select the tables.
   task automatic write_sim_mode(input logic [MODE_W-1:0] mode);
      req_ch.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {CSR_SIM_MODE, 2'b00};
      csr_pwdata  <= {(CSR_DATA_W-MODE_W)'($urandom), mode};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly a small window of nodes so that gates read values set earlier;
   // now and then anywhere in the store.
   function automatic logic [NODE_W-1:0] pool_node(input logic [NODE_W-1:0] base);
      if ($urandom_range(99) < 10)
         return NODE_W'($urandom);
      return base + NODE_W'($urandom_range(0, POOL_SPAN - 1));
   endfunction

   task automatic run_random_phase(input int unsigned quota);
      int unsigned       start;
      int unsigned       pick;
      int unsigned       fanins;
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] base;
      logic [NODE_W-1:0] dest;
      logic [NODE_W-1:0] src;
      start = sent_count;
      base  = NODE_W'($urandom_range(0, (1 << NODE_W) - POOL_SPAN));
      while (sent_count - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            // primary input, pattern values 6 and 7 included
            dest = pool_node(base);
            send_edge(KIND_INPUT, dest, NODE_W'($urandom), VALUE_W'($urandom),
                      1'($urandom), 1'b1);
            last_dest = dest;
         end else if (pick < 85) begin
            // well-formed gate; edges often read the gate just written
            kind   = KIND_W'($urandom_range(KIND_AND, KIND_FROM));
            fanins = (kind >= KIND_BUFF) ? $urandom_range(1, 3) : $urandom_range(1, 5);
            dest   = pool_node(base);
            for (int unsigned k = 0; k < fanins; k++) begin
               src = ($urandom_range(99) < 30) ? last_dest : pool_node(base);
               send_edge(kind, dest, src, VALUE_W'($urandom), k == 0, k == fanins - 1);
            end
            last_dest = dest;
         end else if (pick < 92) begin
            // unknown kinds re-emit the stored value
            send_edge(KIND_W'($urandom_range(KIND_OTHER, KIND_TOP)), pool_node(base),
                      pool_node(base), VALUE_W'($urandom), 1'($urandom), 1'b1);
         end else begin
            // noise: broken sequences, stray first/last marks
            send_edge(KIND_W'($urandom), pool_node(base), pool_node(base),
                      VALUE_W'($urandom), 1'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      logic [MODE_W-1:0] phase_modes [6];
      phase_modes = '{MODE_ROBUST, MODE_NONROBUST, MODE_FUNCTIONAL, MODE_FUNC_ALIAS,
                      MODE_NONROBUST, MODE_ROBUST};

      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = KIND_INPUT;
      req_ch.dest_node     = '0;
      req_ch.fanin_node    = '0;
      req_ch.pattern_value = V_S0;
      req_ch.first_fanin   = 1'b0;
      req_ch.last_fanin    = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      req_idle_pct         = 30;
      rsp_idle_pct         = 50;
      stall_token          = 0;
      sent_count           = 0;
      last_dest            = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The clearing pass after reset holds off requests; the handshake
      // wait in send_edge absorbs it.
      write_sim_mode(MODE_ROBUST);

      // Directed part: every kind at least once, robust tables.
      // Primary inputs: all six codes, both saturated patterns, top node.
      for (int unsigned n = 0; n < 8; n++)
         send_edge(KIND_INPUT, NODE_W'(n), '0, VALUE_W'(n), 1'b1, 1'b1);
      send_edge(KIND_INPUT, '1, '0, V_R1, 1'b1, 1'b1);
      // later edge with no first edge since reset: folds into S0
      send_edge(KIND_AND, 10'd20, '1, V_S0, 1'b0, 1'b1);
      send_edge(KIND_AND, 10'd21, 10'd1, V_S0, 1'b1, 1'b0);
      send_edge(KIND_AND, 10'd21, 10'd3, V_S0, 1'b0, 1'b1);
      send_edge(KIND_NAND, 10'd22, 10'd2, V_S0, 1'b1, 1'b1);
      send_edge(KIND_OR, 10'd23, 10'd1, V_S0, 1'b1, 1'b0);
      send_edge(KIND_OR, 10'd23, 10'd2, V_S0, 1'b0, 1'b1);
      send_edge(KIND_NOR, 10'd24, 10'd23, V_S0, 1'b1, 1'b1);
      send_edge(KIND_XOR, 10'd25, 10'd1, V_S0, 1'b1, 1'b0);
      send_edge(KIND_XOR, 10'd25, 10'd2, V_S0, 1'b0, 1'b1);
      send_edge(KIND_XNOR, 10'd26, 10'd4, V_S0, 1'b1, 1'b0);
      send_edge(KIND_XNOR, 10'd26, 10'd5, V_S0, 1'b0, 1'b1);
      // buffer: the later edge must be ignored
      send_edge(KIND_BUFF, 10'd27, 10'd2, V_S0, 1'b1, 1'b0);
      send_edge(KIND_BUFF, 10'd27, 10'd3, V_S0, 1'b0, 1'b1);
      // inverter reads the node written just before it
      send_edge(KIND_NOT, 10'd28, 10'd27, V_S0, 1'b1, 1'b1);
      send_edge(KIND_FROM, 10'd29, '1, V_S0, 1'b1, 1'b1);
      // unknown kinds: stored value of the gate, store untouched
      send_edge(KIND_OTHER, 10'd28, 10'd0, V_S0, 1'b1, 1'b1);
      send_edge(KIND_TOP, '1, '0, V_X0, 1'b0, 1'b1);

      // Random part: six table settings, mode 3 among them. Receiver-heavy
      // idling first, then sender-heavy, then none at all.
      for (int unsigned p = 0; p < 6; p++) begin
         write_sim_mode(phase_modes[p]);
         req_idle_pct = (p < 2) ? 30 : (p < 4) ? 50 : 0;
         rsp_idle_pct = (p < 2) ? 50 : (p < 4) ? 30 : 0;
         if (p == 1 || p == 4)
            stall_token++;
         run_random_phase(PHASE_ITEMS);
      end

      req_ch.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Summary: %0d requests over six table settings, %0d gate values compared",
               sent_count, results_checked);
      $display("Summary: both idling mixes, no idling, and two long result stalls");
      if (fail_count == 0 && results_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
